>>> sv/brdg_pkg.sv
// Shared types and codes for the blit row descriptor generator.
package brdg_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned DimW    = 13;
  localparam int unsigned PitchW  = 16;
  localparam int unsigned StrideW = 14;
  localparam int unsigned OfsW    = 24;
  localparam int unsigned WordW   = 32;

  localparam logic [12:0] FrameWidthReset = 13'd640;

  // kind field
  localparam logic KindStart = 1'b0;
  localparam logic KindStep  = 1'b1;

  // operation codes
  localparam logic [2:0] OpFill        = 3'd0;
  localparam logic [2:0] OpFrameToBuf  = 3'd1;
  localparam logic [2:0] OpBufToFrame  = 3'd2;
  localparam logic [2:0] OpFrameToFrm  = 3'd3;
  localparam logic [2:0] OpLastValid   = 3'd3;

  // status codes
  localparam logic [1:0] StRow   = 2'd0;
  localparam logic [1:0] StBadOp = 2'd1;
  localparam logic [1:0] StNoRow = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [2:0]          operation;
    logic [CoordW-1:0]   source_x;
    logic [CoordW-1:0]   source_y;
    logic [CoordW-1:0]   dest_x;
    logic [CoordW-1:0]   dest_y;
    logic [DimW-1:0]     rect_width;
    logic [DimW-1:0]     rect_height;
    logic [PitchW-1:0]   buffer_stride_bytes;
    logic [WordW-1:0]    fill_word;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                dest_in_frame;
    logic [OfsW-1:0]     dest_offset;
    logic                src_in_frame;
    logic [OfsW-1:0]     src_offset;
    logic                is_fill;
    logic [WordW-1:0]    fill_value;
    logic [DimW-1:0]     row_words;
    logic                last_row;
  } row_t;

endpackage

>>> sv/brdg_if.sv
// Command and row descriptor channel interfaces.
interface brdg_cmd_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  operation;
  logic [11:0] source_x;
  logic [11:0] source_y;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [12:0] rect_width;
  logic [12:0] rect_height;
  logic [15:0] buffer_stride_bytes;
  logic [31:0] fill_word;

  modport source (
    output valid, kind, operation, source_x, source_y, dest_x, dest_y,
           rect_width, rect_height, buffer_stride_bytes, fill_word,
    input  ready
  );
  modport sink (
    input  valid, kind, operation, source_x, source_y, dest_x, dest_y,
           rect_width, rect_height, buffer_stride_bytes, fill_word,
    output ready
  );
endinterface

interface brdg_row_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        dest_in_frame;
  logic [23:0] dest_offset;
  logic        src_in_frame;
  logic [23:0] src_offset;
  logic        is_fill;
  logic [31:0] fill_value;
  logic [12:0] row_words;
  logic        last_row;

  modport source (
    output valid, status, dest_in_frame, dest_offset, src_in_frame, src_offset,
           is_fill, fill_value, row_words, last_row,
    input  ready
  );
  modport sink (
    input  valid, status, dest_in_frame, dest_offset, src_in_frame, src_offset,
           is_fill, fill_value, row_words, last_row,
    output ready
  );
endinterface

>>> sv/brdg_row_engine.sv
// Command state and row descriptor computation for one word per cycle, while adv_i is high.
module brdg_row_engine #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  brdg_pkg::cmd_t                 cmd_i,
  input  logic [brdg_pkg::DimW-1:0]      frame_width_i,
  output brdg_pkg::row_t                 row_o
);

  localparam logic [14:0] MaxDimW = 15'(MAX_DIM);

  logic                              active_q, active_d;
  logic [1:0]                        cur_op_q, cur_op_d;
  logic [brdg_pkg::OfsW-1:0]         dest_ofs_q, dest_ofs_d;
  logic [brdg_pkg::OfsW-1:0]         src_ofs_q, src_ofs_d;
  logic [brdg_pkg::DimW-1:0]         rows_rem_q, rows_rem_d;
  logic [brdg_pkg::DimW-1:0]         row_len_q, row_len_d;
  logic [brdg_pkg::WordW-1:0]        fill_q, fill_d;
  logic [brdg_pkg::StrideW-1:0]      buf_stride_q, buf_stride_d;

  logic [brdg_pkg::DimW-1:0]         w_sat, h_sat;
  logic [brdg_pkg::StrideW-1:0]      new_stride, st_dst, st_src, run_dst, run_src;
  logic [brdg_pkg::StrideW-1:0]      fw_ext;
  logic [25:0]                       dst_prod, src_prod;
  logic                              fill_row;

  assign fw_ext = {1'b0, frame_width_i};

  // start-path arithmetic: saturate size, derive strides, corner offsets
  always_comb begin
    w_sat = ({2'b00, cmd_i.rect_width} > MaxDimW) ? 13'(MaxDimW) : cmd_i.rect_width;
    h_sat = ({2'b00, cmd_i.rect_height} > MaxDimW) ? 13'(MaxDimW) : cmd_i.rect_height;
    new_stride = (cmd_i.buffer_stride_bytes == '0) ? {1'b0, w_sat}
                                                   : cmd_i.buffer_stride_bytes[15:2];
    st_dst = (cmd_i.operation == brdg_pkg::OpFrameToBuf) ? new_stride : fw_ext;
    st_src = (cmd_i.operation == brdg_pkg::OpBufToFrame) ? new_stride : fw_ext;
    dst_prod = st_dst * cmd_i.dest_y;
    src_prod = st_src * cmd_i.source_y;
    run_dst = ({1'b0, cur_op_q} == brdg_pkg::OpFrameToBuf) ? buf_stride_q : fw_ext;
    run_src = ({1'b0, cur_op_q} == brdg_pkg::OpBufToFrame) ? buf_stride_q : fw_ext;
  end

  always_comb begin
    active_d     = active_q;
    cur_op_d     = cur_op_q;
    dest_ofs_d   = dest_ofs_q;
    src_ofs_d    = src_ofs_q;
    rows_rem_d   = rows_rem_q;
    row_len_d    = row_len_q;
    fill_d       = fill_q;
    buf_stride_d = buf_stride_q;
    row_o          = '0;
    row_o.status   = brdg_pkg::StNoRow;
    row_o.last_row = 1'b1;

    if (cmd_i.kind == brdg_pkg::KindStart) begin
      active_d = 1'b0;
      if (cmd_i.operation > brdg_pkg::OpLastValid) begin
        row_o.status = brdg_pkg::StBadOp;
      end else if (h_sat != '0) begin
        cur_op_d     = cmd_i.operation[1:0];
        row_len_d    = w_sat;
        fill_d       = cmd_i.fill_word;
        buf_stride_d = new_stride;
        dest_ofs_d   = 24'(dst_prod + 26'(cmd_i.dest_x));
        src_ofs_d    = (cmd_i.operation == brdg_pkg::OpFill) ? '0
                       : 24'(src_prod + 26'(cmd_i.source_x));
        rows_rem_d   = h_sat - 13'd1;
        active_d     = (rows_rem_d != '0);
        row_o.status = brdg_pkg::StRow;
      end
    end else if (active_q) begin
      dest_ofs_d = dest_ofs_q + 24'(run_dst);
      if ({1'b0, cur_op_q} != brdg_pkg::OpFill) begin
        src_ofs_d = src_ofs_q + 24'(run_src);
      end
      rows_rem_d   = rows_rem_q - 13'd1;
      active_d     = (rows_rem_d != '0);
      row_o.status = brdg_pkg::StRow;
    end

    fill_row = ({1'b0, cur_op_d} == brdg_pkg::OpFill);
    if (row_o.status == brdg_pkg::StRow) begin
      row_o.dest_in_frame = ({1'b0, cur_op_d} != brdg_pkg::OpFrameToBuf);
      row_o.dest_offset   = dest_ofs_d;
      row_o.src_in_frame  = !fill_row && (({1'b0, cur_op_d} == brdg_pkg::OpFrameToBuf) ||
                                          ({1'b0, cur_op_d} == brdg_pkg::OpFrameToFrm));
      row_o.src_offset    = fill_row ? '0 : src_ofs_d;
      row_o.is_fill       = fill_row;
      row_o.fill_value    = fill_row ? fill_d : '0;
      row_o.row_words     = row_len_d;
      row_o.last_row      = (rows_rem_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cur_op_q     <= '0;
      dest_ofs_q   <= '0;
      src_ofs_q    <= '0;
      rows_rem_q   <= '0;
      row_len_q    <= '0;
      fill_q       <= '0;
      buf_stride_q <= '0;
    end else if (adv_i) begin
      active_q     <= active_d;
      cur_op_q     <= cur_op_d;
      dest_ofs_q   <= dest_ofs_d;
      src_ofs_q    <= src_ofs_d;
      rows_rem_q   <= rows_rem_d;
      row_len_q    <= row_len_d;
      fill_q       <= fill_d;
      buf_stride_q <= buf_stride_d;
    end
  end

endmodule

>>> sv/blit_row_descriptor_generator_unit.sv
// Top level of the blit row descriptor generator.
//
// cmd_i takes command words: a start word carries a fill or copy command
// (corners, size, buffer pitch, fill word), a step word asks for the next
// row. Every word gives exactly one descriptor word on row_o: destination
// and source pixel offsets, their spaces, row length and a last-row mark, or a
// status word for a bad operation or when there is no row. The user must load
// frame_width via cfg_we_i / cfg_wdata_i only while the unit is idle (unchecked).
//
// Two register stages: one input register, then the row computation (two
// 14x12 multiplies on a start, one add per stride on a step) into the output
// register. row_o.valid rises once the word has moved from the input register
// through the row computation into the output register. Throughput is one
// word per cycle while row_o.ready is high; the input register can still take a
// word while the output register waits on a stalled receiver, and cmd_i.ready
// drops only once both hold a word and row_o.ready is low.
//
// Reset empties both register stages and clears the command state; frame_width
// returns to 640.
module blit_row_descriptor_generator_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [12:0]         cfg_wdata_i,
  brdg_cmd_if.sink            cmd_i,
  brdg_row_if.source          row_o
);

  logic [brdg_pkg::DimW-1:0]          fw_q;
  logic                               in_vld_q;
  brdg_pkg::cmd_t                     cmd_q, cmd_d;
  logic                               out_vld_q;
  brdg_pkg::row_t                     out_q, row_next;
  logic                               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= brdg_pkg::FrameWidthReset;
    end else if (cfg_we_i) begin
      fw_q <= cfg_wdata_i;
    end
  end

  // stage advances when the input register holds a word and the output can take it
  assign adv         = in_vld_q && (!out_vld_q || row_o.ready);
  assign cmd_i.ready = !in_vld_q || adv;

  always_comb begin
    cmd_d.kind                = cmd_i.kind;
    cmd_d.operation           = cmd_i.operation;
    cmd_d.source_x            = cmd_i.source_x;
    cmd_d.source_y            = cmd_i.source_y;
    cmd_d.dest_x              = cmd_i.dest_x;
    cmd_d.dest_y              = cmd_i.dest_y;
    cmd_d.rect_width          = cmd_i.rect_width;
    cmd_d.rect_height         = cmd_i.rect_height;
    cmd_d.buffer_stride_bytes = cmd_i.buffer_stride_bytes;
    cmd_d.fill_word           = cmd_i.fill_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q <= cmd_d;
    end
  end

  brdg_row_engine #(
    .MAX_DIM(MAX_DIM)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .cmd_i         (cmd_q),
    .frame_width_i (fw_q),
    .row_o         (row_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (row_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= row_next;
    end
  end

  assign row_o.valid         = out_vld_q;
  assign row_o.status        = out_q.status;
  assign row_o.dest_in_frame = out_q.dest_in_frame;
  assign row_o.dest_offset   = out_q.dest_offset;
  assign row_o.src_in_frame  = out_q.src_in_frame;
  assign row_o.src_offset    = out_q.src_offset;
  assign row_o.is_fill       = out_q.is_fill;
  assign row_o.fill_value    = out_q.fill_value;
  assign row_o.row_words     = out_q.row_words;
  assign row_o.last_row      = out_q.last_row;

  a_adv_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced stage left no output word");

  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> in_vld_q)
    else $error("accepted command word not held in input register");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status != brdg_pkg::StRow)) |-> out_q.last_row)
    else $error("status word without last-row mark");

  a_fill_no_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.is_fill) |-> (!out_q.src_in_frame && (out_q.src_offset == '0)))
    else $error("fill row carries a source");

endmodule

>>> tb/tb_blit_row_descriptor_generator_unit.sv
// Self-checking testbench for the blit row descriptor generator: directed and random blits.
module tb_blit_row_descriptor_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainTail  = 8;
  localparam int unsigned PhaseWords = 310;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;

  brdg_cmd_if cmd_if ();
  brdg_row_if row_if ();

  blit_row_descriptor_generator_unit #(
    .MAX_DIM(MaxDim)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_if),
    .row_o      (row_if)
  );

  always #5 clk_i = ~clk_i;

  // command words waiting to be driven, descriptors waiting to come back
  brdg_pkg::cmd_t pend_q[$];
  brdg_pkg::row_t row_q[$];
  brdg_pkg::cmd_t cmd_held;
  int unsigned words_queued = 0;
  int unsigned rows_seen = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          jitter_on = 1'b1;

  // blit state as the block should hold it
  logic [12:0] frame_w = brdg_pkg::FrameWidthReset;
  logic        blit_busy = 1'b0;
  logic [2:0]  blit_op = brdg_pkg::OpFill;
  logic [23:0] dst_ofs = '0;
  logic [23:0] src_ofs = '0;
  logic [12:0] rows_left = '0;
  logic [12:0] row_len = '0;
  logic [31:0] fill_hold = '0;
  logic [13:0] buf_pitch = '0;

  task automatic predict_row(input brdg_pkg::cmd_t c);
    brdg_pkg::row_t r;
    logic [12:0] w, h;
    logic [31:0] dstr, sstr;
    r = '0;
    w = (c.rect_width > MaxDim) ? 13'(MaxDim) : c.rect_width;
    h = (c.rect_height > MaxDim) ? 13'(MaxDim) : c.rect_height;
    if (c.kind == brdg_pkg::KindStart && c.operation > brdg_pkg::OpLastValid) begin
      blit_busy = 1'b0;
      r.status = brdg_pkg::StBadOp;
      r.last_row = 1'b1;
    end else if (c.kind == brdg_pkg::KindStart && h == 0) begin
      blit_busy = 1'b0;
      r.status = brdg_pkg::StNoRow;
      r.last_row = 1'b1;
    end else if (c.kind == brdg_pkg::KindStep && !blit_busy) begin
      r.status = brdg_pkg::StNoRow;
      r.last_row = 1'b1;
    end else begin
      if (c.kind == brdg_pkg::KindStart) begin
        blit_op = c.operation;
        row_len = w;
        fill_hold = c.fill_word;
        buf_pitch = (c.buffer_stride_bytes == 0) ? 14'(w) : c.buffer_stride_bytes[15:2];
      end
      dstr = (blit_op == brdg_pkg::OpFrameToBuf) ? 32'(buf_pitch) : 32'(frame_w);
      sstr = (blit_op == brdg_pkg::OpBufToFrame) ? 32'(buf_pitch) : 32'(frame_w);
      if (c.kind == brdg_pkg::KindStart) begin
        dst_ofs = 24'(dstr * c.dest_y + c.dest_x);
        src_ofs = (blit_op == brdg_pkg::OpFill) ? '0 : 24'(sstr * c.source_y + c.source_x);
        rows_left = h - 13'd1;
      end else begin
        dst_ofs = dst_ofs + 24'(dstr);
        if (blit_op != brdg_pkg::OpFill) src_ofs = src_ofs + 24'(sstr);
        rows_left = rows_left - 13'd1;
      end
      blit_busy = (rows_left != 0);
      r.status = brdg_pkg::StRow;
      r.dest_in_frame = (blit_op != brdg_pkg::OpFrameToBuf);
      r.dest_offset = dst_ofs;
      r.is_fill = (blit_op == brdg_pkg::OpFill);
      r.src_in_frame = !r.is_fill && (blit_op == brdg_pkg::OpFrameToBuf ||
                                      blit_op == brdg_pkg::OpFrameToFrm);
      r.src_offset = r.is_fill ? '0 : src_ofs;
      r.fill_value = r.is_fill ? fill_hold : '0;
      r.row_words = row_len;
      r.last_row = (rows_left == 0);
    end
    row_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fault_count++;
    $display("row word %0d: %s got 0x%0h want 0x%0h", rows_seen, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : feeder
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) predict_row(cmd_held);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pend_q.size() != 0 && !(jitter_on && $urandom_range(99) < 9)) begin
          cmd_held = pend_q.pop_front();
          cmd_if.kind <= cmd_held.kind;
          cmd_if.operation <= cmd_held.operation;
          cmd_if.source_x <= cmd_held.source_x;
          cmd_if.source_y <= cmd_held.source_y;
          cmd_if.dest_x <= cmd_held.dest_x;
          cmd_if.dest_y <= cmd_held.dest_y;
          cmd_if.rect_width <= cmd_held.rect_width;
          cmd_if.rect_height <= cmd_held.rect_height;
          cmd_if.buffer_stride_bytes <= cmd_held.buffer_stride_bytes;
          cmd_if.fill_word <= cmd_held.fill_word;
          cmd_if.valid <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : row_checker
    brdg_pkg::row_t got, want;
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
    end else begin
      if (row_if.valid && row_if.ready) begin
        got = '{row_if.status, row_if.dest_in_frame, row_if.dest_offset, row_if.src_in_frame,
                row_if.src_offset, row_if.is_fill, row_if.fill_value, row_if.row_words,
                row_if.last_row};
        if (row_q.size() == 0) begin
          report_mismatch("unexpected word, status", 32'(got.status), '0);
        end else begin
          want = row_q.pop_front();
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("dest_in_frame", 32'(got.dest_in_frame), 32'(want.dest_in_frame));
          check_field("dest_offset", 32'(got.dest_offset), 32'(want.dest_offset));
          check_field("src_in_frame", 32'(got.src_in_frame), 32'(want.src_in_frame));
          check_field("src_offset", 32'(got.src_offset), 32'(want.src_offset));
          check_field("is_fill", 32'(got.is_fill), 32'(want.is_fill));
          check_field("fill_value", got.fill_value, want.fill_value);
          check_field("row_words", 32'(got.row_words), 32'(want.row_words));
          check_field("last_row", 32'(got.last_row), 32'(want.last_row));
        end
        rows_seen++;
      end
      row_if.ready <= !(jitter_on && $urandom_range(99) < 9);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("blit_row_descriptor_generator_unit verification failed");
      $finish;
    end
  end

  task automatic queue_word(input brdg_pkg::cmd_t c);
    pend_q.push_back(c);
    words_queued++;
  endtask

  function automatic brdg_pkg::cmd_t start_word(logic [2:0] op, logic [11:0] sx,
                                                logic [11:0] sy, logic [11:0] dx,
                                                logic [11:0] dy, logic [12:0] w,
                                                logic [12:0] h, logic [15:0] pitch,
                                                logic [31:0] fill);
    brdg_pkg::cmd_t c;
    c = '{brdg_pkg::KindStart, op, sx, sy, dx, dy, w, h, pitch, fill};
    return c;
  endfunction

  // step words carry random junk in the ignored fields
  function automatic brdg_pkg::cmd_t step_word();
    brdg_pkg::cmd_t c;
    logic [127:0]   noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    c = noise[$bits(brdg_pkg::cmd_t)-1:0];
    c.kind = brdg_pkg::KindStep;
    return c;
  endfunction

  function automatic brdg_pkg::cmd_t random_start();
    brdg_pkg::cmd_t c;
    int unsigned    pick;
    c = step_word();
    c.kind = brdg_pkg::KindStart;
    c.operation = ($urandom_range(99) < 6)
                  ? 3'(brdg_pkg::OpLastValid + 1 + $urandom_range(3))
                  : 3'($urandom_range(brdg_pkg::OpLastValid));
    pick = $urandom_range(9);
    if (pick < 6) c.rect_width = 13'($urandom_range(MaxDim));
    else if (pick < 8) c.rect_width = 13'($urandom_range(8191));
    else begin
      case ($urandom_range(3))
        0: c.rect_width = '0;
        1: c.rect_width = 13'd1;
        2: c.rect_width = 13'(MaxDim);
        default: c.rect_width = '1;
      endcase
    end
    pick = $urandom_range(9);
    if (pick < 7) c.rect_height = 13'($urandom_range(12, 1));
    else if (pick == 7) c.rect_height = '0;
    else if (pick == 8) c.rect_height = 13'($urandom_range(64, 13));
    else c.rect_height = 13'($urandom_range(8191));
    pick = $urandom_range(9);
    if (pick < 3) c.buffer_stride_bytes = '0;
    else if (pick == 3) c.buffer_stride_bytes = 16'($urandom_range(3, 1));
    return c;
  endfunction

  // one command followed by its steps; sometimes cut short or run past the end
  task automatic queue_random_blit();
    brdg_pkg::cmd_t c;
    int unsigned    rows, steps;
    c = random_start();
    queue_word(c);
    rows = (c.rect_height > MaxDim) ? MaxDim : c.rect_height;
    if (c.operation > brdg_pkg::OpLastValid || rows == 0) begin
      steps = $urandom_range(2);
    end else begin
      steps = (rows - 1 > 64) ? 64 : rows - 1;
      case ($urandom_range(9))
        0: steps = $urandom_range(steps);
        1: steps = steps + $urandom_range(3, 1);
        default: ;
      endcase
    end
    repeat (steps) queue_word(step_word());
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || cmd_if.valid || row_q.size() != 0);
    repeat (DrainTail) @(negedge clk_i);
  endtask

  task automatic load_frame_width(logic [12:0] fw);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= fw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_w = fw;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [12:0] fw_plan[6];
    int unsigned target;
    cmd_if.valid = 1'b0;
    cmd_if.kind = brdg_pkg::KindStart;
    cmd_if.operation = brdg_pkg::OpFill;
    cmd_if.source_x = '0;
    cmd_if.source_y = '0;
    cmd_if.dest_x = '0;
    cmd_if.dest_y = '0;
    cmd_if.rect_width = '0;
    cmd_if.rect_height = '0;
    cmd_if.buffer_stride_bytes = '0;
    cmd_if.fill_word = '0;
    row_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, at the reset frame width
    queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpFill, '1, '1, '1, '1, 13'(MaxDim), 13'd3, '1, '1));
    repeat (3) queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpFrameToBuf, '1, '1, '0, 12'd1, 13'd1, 13'd2, '0, '1));
    queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpBufToFrame, 12'd7, 12'd5, 12'd9, 12'd3, 13'd20, 13'd2,
                          16'd3, '0));
    queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpFrameToFrm, 12'd1, 12'd2, 12'd3, 12'd4, '0, 13'd1,
                          '0, '0));
    queue_word(start_word(brdg_pkg::OpFrameToBuf, '1, '1, '1, '1, '1, '1, '1,
                          32'h5a5a_a5a5));
    repeat (2) queue_word(step_word());
    // a new command abandons the running one
    queue_word(start_word(brdg_pkg::OpBufToFrame, '1, '1, '0, '0, 13'd8, 13'd2, 16'd4, '0));
    queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpFill, '0, '0, 12'd2, 12'd2, 13'd4, '0, '0,
                          32'h1234_5678));
    queue_word(step_word());
    queue_word(start_word(brdg_pkg::OpFill, '0, '0, '0, '0, 13'd4, 13'd5, '0,
                          32'hcafe_f00d));
    for (int j = 1; j <= 4; j++)
      queue_word(start_word(3'(brdg_pkg::OpLastValid + j), '1, '1, '1, '1, '1, '1, '1, '1));
    queue_word(step_word());
    wait_drained();

    fw_plan = '{13'd1, 13'(MaxDim), 13'd0, 13'h1fff, 13'($urandom_range(8191)),
                brdg_pkg::FrameWidthReset};
    foreach (fw_plan[p]) begin
      load_frame_width(fw_plan[p]);
      jitter_on = (p != 2);
      target = words_queued + PhaseWords / 2;
      while (words_queued < target) queue_random_blit();
      // hold the sender until everything is back, mid command stream
      wait_drained();
      target = words_queued + PhaseWords / 2;
      while (words_queued < target) queue_random_blit();
      // zero-height start leaves the unit idle before the next width change
      queue_word(start_word(brdg_pkg::OpFill, '0, '0, '0, '0, '0, '0, '0, '0));
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("blit_row_descriptor_generator_unit verification clean");
    end else begin
      $display("blit_row_descriptor_generator_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/brdg_pkg.sv
sv/brdg_if.sv
sv/brdg_row_engine.sv
sv/blit_row_descriptor_generator_unit.sv
tb/tb_blit_row_descriptor_generator_unit.sv
